/* rtl/flv_tcc_pkg.sv */
// Package for the FLV tag chain checker: widths, verdict codes, result type
// and the small saturating length helpers. No dependencies.
package flv_tcc_pkg;

  localparam int LENGTH_BITS = 40;
  localparam int OUT_LEN_W   = 40;
  localparam int OUT_DATA_W  = 48;

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [OUT_LEN_W-1:0]   out_len_t;

  localparam len_t     LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam out_len_t OUT_MAX = {OUT_LEN_W{1'b1}};

  localparam logic [1:0] V_END    = 2'd0;
  localparam logic [1:0] V_BROKEN = 2'd1;
  localparam logic [1:0] V_HEADER = 2'd2;
  localparam logic [1:0] V_INTACT = 2'd3;

  typedef struct packed {
    logic       valid;
    logic [1:0] verdict;
    out_len_t   file_length;
  } res_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] n);
    logic [7:0] r;
    case (n)
      2'd0:    r = 8'h46;
      2'd1:    r = 8'h4c;
      2'd2:    r = 8'h56;
      default: r = 8'h01;
    endcase
    return r;
  endfunction

  function automatic len_t sat_add(input len_t a, input logic [24:0] b);
    logic [LENGTH_BITS:0] s;
    s = {1'b0, a} + (LENGTH_BITS+1)'(b);
    return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
  endfunction

  function automatic out_len_t clip_len(input len_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'(OUT_MAX)) ? OUT_MAX : w[OUT_LEN_W-1:0];
  endfunction

endpackage

/* rtl/flv_tcc_parser.sv */
// Byte-wise header and tag chain parser: state registers plus the
// single-pass next-state and verdict logic. Depends on flv_tcc_pkg.
module flv_tcc_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output flv_tcc_pkg::res_t res
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_WAIT   = 3'd1;
  localparam logic [2:0] PH_TAG    = 3'd2;
  localparam logic [2:0] PH_DONE   = 3'd3;

  logic [2:0]         phase_r, phase_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic [31:0]        shift_r, shift_nxt;
  flv_tcc_pkg::len_t  offset_r, offset_nxt;
  flv_tcc_pkg::len_t  nts_r, nts_nxt;
  logic [23:0]        last_size_r, last_size_nxt;
  logic               first_tag_r, first_tag_nxt;
  logic               given_r, given_nxt;

  logic               emit;
  logic [1:0]         verdict;
  flv_tcc_pkg::len_t  len;
  flv_tcc_pkg::len_t  off_inc;
  logic [31:0]        sh_new;
  logic [31:0]        tsh;
  logic [3:0]         n;
  logic               in_tag;
  logic               stop;

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    offset_nxt    = offset_r;
    nts_nxt       = nts_r;
    last_size_nxt = last_size_r;
    first_tag_nxt = first_tag_r;
    given_nxt     = given_r;
    emit          = 1'b0;
    verdict       = flv_tcc_pkg::V_END;
    len           = '0;
    off_inc       = flv_tcc_pkg::sat_add(offset_r, 25'd1);
    sh_new        = {shift_r[23:0], data_byte};
    in_tag        = (phase_r == PH_TAG) || (offset_r == nts_r);
    n             = (phase_r == PH_TAG) ? cnt_r : 4'd0;
    tsh           = (phase_r == PH_TAG) ? shift_r : 32'd0;
    stop          = tsh[31] || (data_byte != 8'd0);

    if (accept && phase_r != PH_DONE) begin
      offset_nxt = off_inc;
      if (phase_r == PH_HEADER) begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r < 4'd4) begin
          if (data_byte != flv_tcc_pkg::sig_byte(cnt_r[1:0])) begin
            emit    = 1'b1;
            verdict = flv_tcc_pkg::V_HEADER;
          end
        end else if (cnt_r == 4'd4) begin
          shift_nxt = '0;
          if ((data_byte & 8'hfa) != 8'd0) begin
            emit    = 1'b1;
            verdict = flv_tcc_pkg::V_HEADER;
          end
        end else begin
          shift_nxt = sh_new;
          if (cnt_r >= 4'd8) begin
            if (sh_new < 32'd9) begin
              emit    = 1'b1;
              verdict = flv_tcc_pkg::V_HEADER;
            end else begin
              nts_nxt   = flv_tcc_pkg::LENGTH_BITS'(sh_new);
              phase_nxt = PH_WAIT;
              cnt_nxt   = '0;
              shift_nxt = '0;
            end
          end
        end
      end else if (in_tag) begin
        phase_nxt = PH_TAG;
        cnt_nxt   = n + 4'd1;
        shift_nxt = tsh;
        case (n) inside
          [4'd0:4'd2]: shift_nxt = {tsh[23:0], data_byte};
          4'd3: begin
            shift_nxt = '0;
            if (!(({tsh[23:0], data_byte} == 32'd11 + 32'(last_size_r)) ||
                  (({tsh[23:0], data_byte} == 32'd0) && first_tag_r))) begin
              emit    = 1'b1;
              verdict = flv_tcc_pkg::V_BROKEN;
              len     = nts_r;
            end
          end
          4'd4: shift_nxt = {(tsh[31] || ((data_byte & 8'hc0) != 8'd0)), tsh[30:0]};
          [4'd5:4'd7]: shift_nxt = {tsh[31], 7'd0, tsh[15:0], data_byte};
          [4'd8:4'd11]: ;
          4'd12, 4'd13: shift_nxt = {stop, tsh[30:0]};
          4'd14: begin
            if (stop || (tsh[23:0] == 24'd0)) begin
              emit    = 1'b1;
              verdict = flv_tcc_pkg::V_END;
              len     = flv_tcc_pkg::sat_add(nts_r, 25'd4);
            end else begin
              last_size_nxt = tsh[23:0];
              nts_nxt       = flv_tcc_pkg::sat_add(nts_r, 25'd15 + 25'(tsh[23:0]));
              first_tag_nxt = 1'b0;
              phase_nxt     = PH_WAIT;
              cnt_nxt       = '0;
              shift_nxt     = '0;
            end
          end
          default: ;
        endcase
      end
      if (emit) begin
        phase_nxt = PH_DONE;
        given_nxt = 1'b1;
      end
    end

    if (accept && last_byte) begin
      if (!emit && !given_r) begin
        emit    = 1'b1;
        verdict = flv_tcc_pkg::V_INTACT;
        len     = off_inc;
      end
      phase_nxt     = PH_HEADER;
      cnt_nxt       = '0;
      shift_nxt     = '0;
      offset_nxt    = '0;
      nts_nxt       = '0;
      last_size_nxt = '0;
      first_tag_nxt = 1'b1;
      given_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      cnt_r       <= '0;
      shift_r     <= '0;
      offset_r    <= '0;
      nts_r       <= '0;
      last_size_r <= '0;
      first_tag_r <= 1'b1;
      given_r     <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      offset_r    <= offset_nxt;
      nts_r       <= nts_nxt;
      last_size_r <= last_size_nxt;
      first_tag_r <= first_tag_nxt;
      given_r     <= given_nxt;
    end
  end

  assign res.valid       = emit;
  assign res.verdict     = verdict;
  assign res.file_length = flv_tcc_pkg::clip_len(len);

endmodule

/* rtl/flv_tcc_out_buf.sv */
// Result register with a one-entry skid stage, so the parser keeps taking
// bytes while a verdict waits. Depends on flv_tcc_pkg.
module flv_tcc_out_buf (
  input  logic                                clk,
  input  logic                                rst_n,
  input  flv_tcc_pkg::res_t                   res,
  output logic                                room,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [flv_tcc_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic              main_valid_r, main_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  flv_tcc_pkg::res_t main_r, main_nxt;
  flv_tcc_pkg::res_t skid_r, skid_nxt;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || out_tready) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_nxt       = res;
        skid_valid_nxt = res.valid;
      end else begin
        main_nxt       = res;
        main_valid_nxt = res.valid;
      end
    end else if (res.valid) begin
      skid_nxt       = res;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign room       = !skid_valid_r;
  assign out_tvalid = main_valid_r;
  assign out_tdata  = {6'd0, main_r.file_length, main_r.verdict};

endmodule

/* rtl/flv_tag_chain_checker_unit.sv */
// Top level of the FLV tag chain checker: byte stream in, one verdict per file out.
// Depends on flv_tcc_pkg, flv_tcc_parser and flv_tcc_out_buf.
//
// A new byte can be taken every cycle while in_tready is high; the parser
// state update is the single register stage per byte. A verdict is formed
// from the byte that decides it and lands in the output result register, or
// in its one-entry skid stage while the sink stalls; in_tready drops only
// when both hold a verdict the sink has not yet taken. One verdict per file;
// in_tlast marks the final byte, after which the parser starts over.
module flv_tag_chain_checker_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] data_byte
  input  logic                                in_tlast,   // last_byte
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [flv_tcc_pkg::OUT_DATA_W-1:0]  out_tdata   // [1:0] verdict, [41:2] file_length
);

  flv_tcc_pkg::res_t res;
  logic              room;

  assign in_tready = room;

  flv_tcc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_tvalid && room),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .res       (res)
  );

  flv_tcc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_hdr_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == flv_tcc_pkg::V_HEADER) |-> (out_tdata[41:2] == '0))
    else $error("header reject with nonzero length");

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("skid stage full while result register empty");

  a_result_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> (in_tvalid && in_tready))
    else $error("result produced without an accepted item");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:42] == 6'd0))
    else $error("nonzero pad bits in out_tdata");

endmodule
